[rtl/core/cease_pkg.sv]
// Shared types and constants for the cubic ease-out scroll animator.
// No dependencies; used by the channel interfaces, the arithmetic unit and the top level.
package cease_pkg;

  localparam int unsigned LAYERS_DEF     = 8;
  localparam int unsigned MAX_FRAMES_DEF = 255;

  localparam int unsigned LAYER_W = 3;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned DELTA_W = COORD_W + 1;
  localparam int unsigned OPA_W   = 3 * FRAME_W;
  localparam int unsigned OPB_W   = COORD_W;
  localparam int unsigned QUO_W   = COORD_W;
  localparam int unsigned PROD_W  = OPA_W + OPB_W;

  typedef enum logic [1:0] {
    CMD_START_ABS = 2'd0,
    CMD_START_REL = 2'd1,
    CMD_TICK      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    UOP_IDLE,
    UOP_MUL,
    UOP_DIV_LOAD,
    UOP_DIV_STEP
  } uop_e;

  typedef struct packed {
    uop_e             op;
    logic [OPA_W-1:0] opa;
    logic [OPB_W-1:0] opb;
  } unit_ctrl_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
  } unit_stat_t;

endpackage

[rtl/core/cease_if.sv]
// Valid/ready channels for requests into and results out of the animator.
// Depends on cease_pkg for field widths.
interface cease_req_if;
  import cease_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [LAYER_W-1:0]        layer;
  logic signed [COORD_W-1:0] goal_x;
  logic signed [COORD_W-1:0] goal_y;
  logic [FRAME_W-1:0]        frame_count;
  logic                      skip_allowed;
  logic                      key_down;

  modport source (
    output valid, command, layer, goal_x, goal_y, frame_count, skip_allowed, key_down,
    input  ready
  );
  modport sink (
    input  valid, command, layer, goal_x, goal_y, frame_count, skip_allowed, key_down,
    output ready
  );
endinterface

interface cease_rsp_if;
  import cease_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LAYER_W-1:0]        out_layer;
  logic signed [COORD_W-1:0] scroll_x;
  logic signed [COORD_W-1:0] scroll_y;
  logic                      last;

  modport source (output valid, out_layer, scroll_x, scroll_y, last, input ready);
  modport sink   (input  valid, out_layer, scroll_x, scroll_y, last, output ready);
endinterface

[rtl/core/cease_arith.sv]
// Shared arithmetic unit: registered 24x16 multiplier and one-bit-per-cycle
// restoring divider. Depends on cease_pkg.
module cease_arith (
  input  logic                    clk_i,
  input  cease_pkg::unit_ctrl_t   ctrl_i,
  output cease_pkg::unit_stat_t   stat_o
);
  import cease_pkg::*;

  logic [PROD_W-1:0] prod_q, prod_d;
  logic [OPA_W-1:0]  rem_q, rem_d;
  logic [OPA_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [OPA_W:0]    trial;
  logic [OPA_W:0]    diff;

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[QUO_W-1]};
    diff   = trial - {1'b0, den_q};
    case (ctrl_i.op)
      UOP_MUL: begin
        prod_d = PROD_W'(ctrl_i.opa) * PROD_W'(ctrl_i.opb);
      end
      UOP_DIV_LOAD: begin
        den_d = ctrl_i.opa;
        rem_d = prod_q[PROD_W-1 -: OPA_W];
        quo_d = prod_q[QUO_W-1:0];
      end
      UOP_DIV_STEP: begin
        // remainder stays below the divisor, so no borrow means trial >= divisor
        if (!diff[OPA_W]) begin
          rem_d = diff[OPA_W-1:0];
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = trial[OPA_W-1:0];
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
  end

  assign stat_o.prod = prod_q;
  assign stat_o.quo  = quo_q;

endmodule

[rtl/core/cubic_ease_scroll_animator.sv]
// Cubic ease-out scroll animator: one request per cycle while idle and the result slot is free.
// Start with zero frames, final tick or skip: result is valid the cycle after the request.
// Eased position: no new request is taken until the result leaves S_OUT for the result slot;
// six multiply steps (cubes, then one product per axis), two 16-step divisions.
// Reset clears the per-layer position table and leaves the animation idle.
// Depends on cease_pkg, cease_if (channels) and cease_arith.
module cubic_ease_scroll_animator #(
  parameter int unsigned LAYERS     = cease_pkg::LAYERS_DEF,
  parameter int unsigned MAX_FRAMES = cease_pkg::MAX_FRAMES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cease_req_if.sink    req_i,
  cease_rsp_if.source  rsp_o
);
  import cease_pkg::*;

  localparam int unsigned IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned SLOTS = 2 ** IDX_W;
  localparam int unsigned CNT_W = $clog2(QUO_W);
  localparam logic [FRAME_W-1:0] MaxFrames  = FRAME_W'(MAX_FRAMES);
  localparam logic [LAYER_W:0]   LayerLimit = (LAYER_W + 1)'(LAYERS);
  localparam logic [CNT_W-1:0]   DivLast    = CNT_W'(QUO_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_LOAD, S_DIV, S_FIN, S_OUT} state_e;
  typedef enum logic [2:0] {M_RR, M_RRR, M_NN, M_NNN, M_PROD} mstep_e;

  state_e             state_q, state_d;
  mstep_e             step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               axis_q, axis_d;
  logic               running_q, running_d;
  logic               skip_q, skip_d;
  logic [FRAME_W-1:0] span_q, span_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [FRAME_W-1:0] r_q, r_d;
  logic [LAYER_W-1:0] act_q, act_d;
  logic [DELTA_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [COORD_W-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_W-1:0] pos_x_q [SLOTS];
  logic [COORD_W-1:0] pos_x_d [SLOTS];
  logic [COORD_W-1:0] pos_y_q [SLOTS];
  logic [COORD_W-1:0] pos_y_d [SLOTS];
  logic [OPA_W-1:0]   r3_q, r3_d, den_q, den_d;
  logic [COORD_W-1:0] res_x_q, res_x_d;
  logic               ov_q, ov_d;
  logic [LAYER_W-1:0] ol_q, ol_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic               olast_q, olast_d;

  unit_ctrl_t         ctrl;
  unit_stat_t         stat;

  cmd_e               cmd;
  logic               accept;
  logic               is_start;
  logic               lay_ok;
  logic [IDX_W-1:0]   lay_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [COORD_W-1:0] cur_x, cur_y, new_x, new_y;
  logic [DELTA_W-1:0] dnew_x, dnew_y;
  logic [FRAME_W-1:0] n_clamp;
  logic [DELTA_W-1:0] neg_dx, neg_dy;
  logic [COORD_W-1:0] mag_x, mag_y, mag_cur, tgt_cur, res;
  logic               sign_cur;

  cease_arith u_arith (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  assign cmd      = cmd_e'(req_i.command);
  assign accept   = req_i.valid && req_i.ready;
  assign is_start = (cmd == CMD_START_ABS) || (cmd == CMD_START_REL);
  assign lay_ok   = {1'b0, req_i.layer} < LayerLimit;
  assign lay_idx  = req_i.layer[IDX_W-1:0];
  assign rd_idx   = is_start ? lay_idx : act_q[IDX_W-1:0];
  assign cur_x    = pos_x_q[rd_idx];
  assign cur_y    = pos_y_q[rd_idx];
  assign new_x    = (cmd == CMD_START_REL) ? COORD_W'(req_i.goal_x + cur_x) : req_i.goal_x;
  assign new_y    = (cmd == CMD_START_REL) ? COORD_W'(req_i.goal_y + cur_y) : req_i.goal_y;
  assign dnew_x   = {new_x[COORD_W-1], new_x} - {cur_x[COORD_W-1], cur_x};
  assign dnew_y   = {new_y[COORD_W-1], new_y} - {cur_y[COORD_W-1], cur_y};
  assign n_clamp  = (req_i.frame_count > MaxFrames) ? MaxFrames : req_i.frame_count;

  assign neg_dx   = -dx_q;
  assign neg_dy   = -dy_q;
  assign mag_x    = dx_q[DELTA_W-1] ? neg_dx[COORD_W-1:0] : dx_q[COORD_W-1:0];
  assign mag_y    = dy_q[DELTA_W-1] ? neg_dy[COORD_W-1:0] : dy_q[COORD_W-1:0];
  assign mag_cur  = axis_q ? mag_y : mag_x;
  assign sign_cur = axis_q ? dy_q[DELTA_W-1] : dx_q[DELTA_W-1];
  assign tgt_cur  = axis_q ? tgt_y_q : tgt_x_q;
  // target - trunc(r^3 * diff / n^3), sign applied to the magnitude quotient
  assign res      = sign_cur ? (tgt_cur + stat.quo) : (tgt_cur - stat.quo);

  assign req_i.ready     = (state_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign rsp_o.valid     = ov_q;
  assign rsp_o.out_layer = ol_q;
  assign rsp_o.scroll_x  = ox_q;
  assign rsp_o.scroll_y  = oy_q;
  assign rsp_o.last      = olast_q;

  always_comb begin
    ctrl.op  = UOP_IDLE;
    ctrl.opa = '0;
    ctrl.opb = '0;
    unique case (state_q)
      S_MUL: begin
        ctrl.op = UOP_MUL;
        unique case (step_q)
          M_RR: begin
            ctrl.opa = OPA_W'(r_q);
            ctrl.opb = OPB_W'(r_q);
          end
          M_RRR: begin
            ctrl.opa = stat.prod[OPA_W-1:0];
            ctrl.opb = OPB_W'(r_q);
          end
          M_NN: begin
            ctrl.opa = OPA_W'(span_q);
            ctrl.opb = OPB_W'(span_q);
          end
          M_NNN: begin
            ctrl.opa = stat.prod[OPA_W-1:0];
            ctrl.opb = OPB_W'(span_q);
          end
          default: begin
            ctrl.opa = r3_q;
            ctrl.opb = mag_cur;
          end
        endcase
      end
      S_LOAD: begin
        ctrl.op  = UOP_DIV_LOAD;
        ctrl.opa = den_q;
      end
      S_DIV:   ctrl.op = UOP_DIV_STEP;
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    axis_d    = axis_q;
    running_d = running_q;
    skip_d    = skip_q;
    span_d    = span_q;
    frame_d   = frame_q;
    r_d       = r_q;
    act_d     = act_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    tgt_x_d   = tgt_x_q;
    tgt_y_d   = tgt_y_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    r3_d      = r3_q;
    den_d     = den_q;
    res_x_d   = res_x_q;
    ov_d      = ov_q;
    ol_d      = ol_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    olast_d   = olast_q;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd) inside
            CMD_START_ABS, CMD_START_REL: begin
              if (lay_ok) begin
                act_d            = req_i.layer;
                dx_d             = dnew_x;
                dy_d             = dnew_y;
                pos_x_d[lay_idx] = new_x;
                pos_y_d[lay_idx] = new_y;
                tgt_x_d          = new_x;
                tgt_y_d          = new_y;
                span_d           = n_clamp;
                skip_d           = req_i.skip_allowed;
                if (n_clamp == '0) begin
                  running_d = 1'b0;
                  frame_d   = '0;
                  ov_d      = 1'b1;
                  ol_d      = req_i.layer;
                  ox_d      = new_x;
                  oy_d      = new_y;
                  olast_d   = 1'b1;
                end else begin
                  running_d = 1'b1;
                  frame_d   = FRAME_W'(1);
                  r_d       = n_clamp;
                  step_d    = M_RR;
                  axis_d    = 1'b0;
                  state_d   = S_MUL;
                end
              end
            end
            CMD_TICK: begin
              if (running_q) begin
                if ((req_i.key_down && skip_q) || (frame_q >= span_q)) begin
                  running_d = 1'b0;
                  ov_d      = 1'b1;
                  ol_d      = act_q;
                  ox_d      = cur_x;
                  oy_d      = cur_y;
                  olast_d   = 1'b1;
                end else begin
                  r_d     = span_q - frame_q;
                  frame_d = frame_q + FRAME_W'(1);
                  tgt_x_d = cur_x;
                  tgt_y_d = cur_y;
                  step_d  = M_RR;
                  axis_d  = 1'b0;
                  state_d = S_MUL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        unique case (step_q)
          M_RR:  step_d = M_RRR;
          M_RRR: step_d = M_NN;
          M_NN: begin
            r3_d   = stat.prod[OPA_W-1:0];
            step_d = M_NNN;
          end
          M_NNN: step_d = M_PROD;
          default: begin
            if (!axis_q) begin
              den_d = stat.prod[OPA_W-1:0];
            end
            state_d = S_LOAD;
          end
        endcase
      end
      S_LOAD: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DivLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!axis_q) begin
          res_x_d = res;
          axis_d  = 1'b1;
          step_d  = M_PROD;
          state_d = S_MUL;
        end else begin
          tgt_y_d = res;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          ol_d    = act_q;
          ox_d    = res_x_q;
          oy_d    = tgt_y_q;
          olast_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= M_RR;
      cnt_q     <= '0;
      axis_q    <= 1'b0;
      running_q <= 1'b0;
      skip_q    <= 1'b0;
      span_q    <= '0;
      frame_q   <= '0;
      r_q       <= '0;
      act_q     <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
      end
      r3_q      <= '0;
      den_q     <= '0;
      res_x_q   <= '0;
      ov_q      <= 1'b0;
      ol_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      axis_q    <= axis_d;
      running_q <= running_d;
      skip_q    <= skip_d;
      span_q    <= span_d;
      frame_q   <= frame_d;
      r_q       <= r_d;
      act_q     <= act_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      tgt_x_q   <= tgt_x_d;
      tgt_y_q   <= tgt_y_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      r3_q      <= r3_d;
      den_q     <= den_d;
      res_x_q   <= res_x_d;
      ov_q      <= ov_d;
      ol_q      <= ol_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      olast_q   <= olast_d;
    end
  end

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_start && lay_ok && (n_clamp != '0)) |=> running_q)
    else $error("start request with nonzero frames did not arm the animation");

  a_frame_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (frame_q <= span_q))
    else $error("frame index ran past the frame count");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (den_q != '0))
    else $error("division started with a zero divisor");

  a_quo_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (stat.quo <= mag_cur))
    else $error("eased offset exceeds the distance to the target");

endmodule

[sim/testbench.sv]
// Self-checking testbench for cubic_ease_scroll_animator: directed and random requests on the
// request channel, positions predicted per request and checked on the result channel.
// Depends on cease_pkg, cease_if and the animator RTL.
module testbench;
  import cease_pkg::*;

  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam int         ITEMS        = 1300;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [1:0]         command;
    logic [LAYER_W-1:0] layer;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [FRAME_W-1:0] frame_count;
    logic               skip_allowed;
    logic               key_down;
  } scroll_req_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } scroll_pos_t;

  class ease_scoreboard;
    logic [COORD_W-1:0] pos_x [LAYERS_DEF];
    logic [COORD_W-1:0] pos_y [LAYERS_DEF];
    logic [LAYER_W-1:0] act_layer;
    int                 dx, dy, span, fidx;
    bit                 skip_en, running;
    scroll_pos_t        expected_q[$];
    int                 errors, checked, finals;

    function new();
      foreach (pos_x[i]) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
      end
      act_layer = '0;
      dx = 0; dy = 0; span = 0; fidx = 0;
      skip_en = 0; running = 0;
      errors = 0; checked = 0; finals = 0;
    endfunction

    // target - (N-f)^3 * diff / N^3, truncating toward zero
    function logic [COORD_W-1:0] ease(logic [COORD_W-1:0] target, int diff, int f);
      longint rem_cube, span_cube, v;
      rem_cube  = longint'(span - f) * (span - f) * (span - f);
      span_cube = longint'(span) * span * span;
      if (span_cube == 0) return target;
      v = longint'($signed(target)) - (rem_cube * diff) / span_cube;
      return v[COORD_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // returns 1 when the request produces a position
    function bit note_request(scroll_req_t q);
      logic [COORD_W-1:0] tx, ty;
      scroll_pos_t        e;
      int                 n;
      if (q.command == CMD_START_ABS || q.command == CMD_START_REL) begin
        n = int'(q.frame_count);
        if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
        tx = q.goal_x;
        ty = q.goal_y;
        if (q.command == CMD_START_REL) begin
          tx = q.goal_x + pos_x[q.layer];
          ty = q.goal_y + pos_y[q.layer];
        end
        act_layer = q.layer;
        dx = int'($signed(tx)) - int'($signed(pos_x[q.layer]));
        dy = int'($signed(ty)) - int'($signed(pos_y[q.layer]));
        pos_x[q.layer] = tx;
        pos_y[q.layer] = ty;
        span = n;
        skip_en = q.skip_allowed;
        if (n == 0) begin
          running = 0;
          fidx = 0;
          e = '{act_layer, tx, ty, 1'b1};
        end else begin
          running = 1;
          fidx = 1;
          e = '{act_layer, ease(tx, dx, 0), ease(ty, dy, 0), 1'b0};
        end
        expected_q.push_back(e);
        return 1;
      end
      if (q.command == CMD_TICK && running) begin
        tx = pos_x[act_layer];
        ty = pos_y[act_layer];
        if ((q.key_down && skip_en) || fidx >= span) begin
          running = 0;
          e = '{act_layer, tx, ty, 1'b1};
        end else begin
          e = '{act_layer, ease(tx, dx, fidx), ease(ty, dy, fidx), 1'b0};
          fidx = (fidx + 1) & 8'hff;
        end
        expected_q.push_back(e);
        return 1;
      end
      return 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(scroll_pos_t got);
      scroll_pos_t exp;
      string       bad;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected position layer %0d x %0d y %0d last %0b",
                         got.layer, $signed(got.x), $signed(got.y), got.last));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.last) finals++;
      bad = "";
      if (got.layer !== exp.layer)
        bad = {bad, $sformatf(" layer %0d/%0d", got.layer, exp.layer)};
      if (got.x !== exp.x)
        bad = {bad, $sformatf(" x %0d/%0d", $signed(got.x), $signed(exp.x))};
      if (got.y !== exp.y)
        bad = {bad, $sformatf(" y %0d/%0d", $signed(got.y), $signed(exp.y))};
      if (got.last !== exp.last)
        bad = {bad, $sformatf(" last %0b/%0b", got.last, exp.last)};
      if (bad != "") report({"position #", $sformatf("%0d", checked), " got/exp:", bad});
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d positions never arrived", expected_q.size()));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cease_req_if req_if ();
  cease_rsp_if rsp_if ();

  cubic_ease_scroll_animator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ease_scoreboard sb = new();

  int sent_total  = 0;
  int effective   = 0;
  int starts      = 0;
  int burst_left  = 0;
  int quiet_count = 0;
  int hold_reqs   = 0;

  always #1 clk_i = ~clk_i;

  // receiver: changing stall pattern, plus long hold-off on request
  initial begin
    int mode, mode_left, hold_left, hold_seen;
    mode = 0; mode_left = 0; hold_left = 0; hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_result('{rsp_if.out_layer, rsp_if.scroll_x, rsp_if.scroll_y, rsp_if.last});
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("** cubic_ease_scroll_animator: FAILED **");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic offer(scroll_req_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.command      <= it.command;
    req_if.layer        <= it.layer;
    req_if.goal_x       <= it.goal_x;
    req_if.goal_y       <= it.goal_y;
    req_if.frame_count  <= it.frame_count;
    req_if.skip_allowed <= it.skip_allowed;
    req_if.key_down     <= it.key_down;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sent_total++;
    if (it.command == CMD_START_ABS || it.command == CMD_START_REL) starts++;
    if (sb.note_request(it)) effective++;
  endtask

  task automatic send(logic [1:0] cmd, logic [LAYER_W-1:0] lay, logic [COORD_W-1:0] gx,
                      logic [COORD_W-1:0] gy, logic [FRAME_W-1:0] n, logic skip, logic key);
    offer('{cmd, lay, gx, gy, n, skip, key});
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frames();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 90) return FRAME_W'($urandom_range(1, 12));
    if (r < 97) return FRAME_W'($urandom_range(13, 60));
    if (r < 98) return 8'd255;
    return FRAME_W'($urandom_range(61, 255));
  endfunction

  initial begin
    int sel, ticks_left, n;
    bit hold1, hold2, paused;
    hold1 = 0; hold2 = 0; paused = 0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_TICK;
    req_if.layer        <= '0;
    req_if.goal_x       <= '0;
    req_if.goal_y       <= '0;
    req_if.frame_count  <= '0;
    req_if.skip_allowed <= 1'b0;
    req_if.key_down     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, unused code, extremes, wrap, skip, restart
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b0);
    send(CMD_NOP,       3'd7, 16'hffff, 16'hffff, 8'hff,  1'b1, 1'b1);
    send(CMD_START_ABS, 3'd0, 16'h7fff, 16'h8000, 8'd0,   1'b0, 1'b0);
    send(CMD_START_ABS, 3'd7, 16'h8000, 16'h7fff, 8'd1,   1'b1, 1'b1);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b0);
    send(CMD_START_REL, 3'd7, 16'hffff, 16'h0001, 8'd2,   1'b1, 1'b1);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b1);
    send(CMD_START_ABS, 3'd3, 16'd1000, -16'sd1000, 8'd255, 1'b0, 1'b0);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b1);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b0);
    send(CMD_START_REL, 3'd3, -16'sd5000, 16'd5000, 8'd3, 1'b0, 1'b0);
    repeat (4) send(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0);
    send(CMD_START_REL, 3'd0, 16'h7fff, 16'h8000, 8'd5,   1'b1, 1'b0);
    send(CMD_NOP,       3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b0);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b0);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b1);
    send(CMD_START_ABS, 3'd5, 16'h0000, 16'h0000, 8'd4,   1'b0, 1'b0);
    send(CMD_TICK,      3'd0, 16'h0000, 16'h0000, 8'd0,   1'b0, 1'b1);
    repeat (3) send(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0);
    drain();

    while (effective < ITEMS) begin
      if (!hold1 && effective >= 300) begin
        hold1 = 1;
        hold_reqs++;
      end
      if (!paused && effective >= 650) begin
        paused = 1;
        drain();
      end
      if (!hold2 && effective >= 900) begin
        hold2 = 1;
        hold_reqs++;
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        repeat ($urandom_range(1, 4))
          send(2'($urandom_range(0, 3)), LAYER_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), FRAME_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        n = int'(pick_frames());
        send(($urandom_range(0, 9) < 3) ? CMD_START_REL : CMD_START_ABS,
             LAYER_W'($urandom), pick_coord(), pick_coord(), FRAME_W'(n), 1'($urandom),
             1'($urandom));
        ticks_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, n)) + 1 : -1;
        while (sb.running && ticks_left != 1) begin
          send(CMD_TICK, LAYER_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               FRAME_W'($urandom), 1'($urandom), ($urandom_range(0, 23) == 0));
          ticks_left--;
        end
        if (!sb.running && $urandom_range(0, 3) == 0)
          send(CMD_TICK, LAYER_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               FRAME_W'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();
    $display("Sent %0d requests (%0d starts, %0d producing a position); checked %0d positions,",
             sent_total, starts, effective, sb.checked);
    $display("%0d of them final, through skips, restarts, wraps, idle ticks and result stalls.",
             sb.finals);
    if (sb.errors == 0) begin
      $display("** cubic_ease_scroll_animator: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** cubic_ease_scroll_animator: FAILED **");
    end
    $finish;
  end

endmodule
